// ===== sv/msks_pkg.sv =====
// Shared types, register codes and reset values for the soft-knee limiter and level statistics.
package msks_pkg;

    // Accumulator width of the magnitude sum; the result shows its low 48 bits
    localparam int SUM_WIDTH     = 48;
    localparam int ABS_SUM_WIDTH = 48;

    // Register map decode width (four 32-bit registers)
    localparam int ADDR_WIDTH = 4;
    localparam int DATA_WIDTH = 32;

    // Register reset values
    localparam logic [3:0]  GAIN_SHIFT_RESET     = 4'd2;
    localparam logic [14:0] KNEE_THRESHOLD_RESET = 15'd24576;
    localparam logic [14:0] KNEE_HEADROOM_RESET  = 15'd8191;
    localparam logic [10:0] FRAME_LENGTH_RESET   = 11'd320;

    // Largest gain exponent; anything above saturates to a shift of zero
    localparam logic [3:0]  GAIN_SHIFT_MAX = 4'd8;

    // Statistics restart values
    localparam logic signed [15:0] LEVEL_MIN_INIT = 16'sh7FFF;
    localparam logic signed [15:0] LEVEL_MAX_INIT = 16'sh8000;
    localparam logic [15:0]        BITS_OR_INIT   = 16'h0000;
    localparam logic [15:0]        BITS_AND_INIT  = 16'hFFFF;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_GAIN_SHIFT     = 2'd0,
        REG_KNEE_THRESHOLD = 2'd1,
        REG_KNEE_HEADROOM  = 2'd2,
        REG_FRAME_LENGTH   = 2'd3
    } reg_index_t;

    // Current configuration
    typedef struct packed {
        logic [3:0]  gain_shift;
        logic [14:0] knee_threshold;
        logic [14:0] knee_headroom;
        logic [10:0] frame_length;
    } cfg_t;

    // Input item
    typedef struct packed {
        logic [31:0] slot_word;
        logic        clear_stats;
    } sample_t;

    // Limiter outcome for one sample
    typedef struct packed {
        logic [15:0] pcm;
        logic        clip;
    } cond_t;

    // Result item
    typedef struct packed {
        logic signed [15:0]         pcm_sample;
        logic                       clipped;
        logic                       frame_end;
        logic signed [15:0]         level_min;
        logic signed [15:0]         level_max;
        logic [15:0]                bits_or;
        logic [15:0]                bits_and;
        logic [31:0]                sample_count;
        logic [ABS_SUM_WIDTH-1:0]   abs_sum;
        logic [31:0]                clip_count;
    } result_t;

endpackage

// ===== sv/msks_cfg_regs.sv =====
// APB register file holding gain, knee and frame settings.
module msks_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msks_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [msks_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [msks_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                               pready,
    output msks_pkg::cfg_t                     cfg
);

    logic [3:0]  gain_shift_reg;
    logic [14:0] knee_threshold_reg;
    logic [14:0] knee_headroom_reg;
    logic [10:0] frame_length_reg;

    logic                 wr_en;
    msks_pkg::reg_index_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = msks_pkg::reg_index_t'(paddr[3:2]);

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_shift_reg     <= msks_pkg::GAIN_SHIFT_RESET;
            knee_threshold_reg <= msks_pkg::KNEE_THRESHOLD_RESET;
            knee_headroom_reg  <= msks_pkg::KNEE_HEADROOM_RESET;
            frame_length_reg   <= msks_pkg::FRAME_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                msks_pkg::REG_GAIN_SHIFT:     gain_shift_reg     <= pwdata[3:0];
                msks_pkg::REG_KNEE_THRESHOLD: knee_threshold_reg <= pwdata[14:0];
                msks_pkg::REG_KNEE_HEADROOM:  knee_headroom_reg  <= pwdata[14:0];
                msks_pkg::REG_FRAME_LENGTH:   frame_length_reg   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_sel)
            msks_pkg::REG_GAIN_SHIFT:     prdata = {28'd0, gain_shift_reg};
            msks_pkg::REG_KNEE_THRESHOLD: prdata = {17'd0, knee_threshold_reg};
            msks_pkg::REG_KNEE_HEADROOM:  prdata = {17'd0, knee_headroom_reg};
            msks_pkg::REG_FRAME_LENGTH:   prdata = {21'd0, frame_length_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.gain_shift     = gain_shift_reg;
    assign cfg.knee_threshold = knee_threshold_reg;
    assign cfg.knee_headroom  = knee_headroom_reg;
    assign cfg.frame_length   = frame_length_reg;

endmodule

// ===== sv/msks_in_stage.sv =====
// Input register stage: captures one sample transfer and holds it until it moves on.
module msks_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  msks_pkg::sample_t sample,
    input  logic              take,
    output logic              stage_valid,
    output msks_pkg::sample_t stage_data
);

    logic              valid_reg;
    logic              valid_next;
    msks_pkg::sample_t data_reg;
    logic              load;

    // Accept when empty or when the held item moves on this cycle
    assign load         = !valid_reg || take;
    assign sample_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = sample_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on every accepted transfer
    always_ff @(posedge clk)
    begin
        if (load && sample_valid)
        begin
            data_reg <= sample;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

// ===== sv/msks_limiter.sv =====
// Gain shift and soft-knee compression of one slot word down to a 16-bit sample.
module msks_limiter (
    input  logic [31:0]     slot_word,
    input  msks_pkg::cfg_t  cfg,
    output msks_pkg::cond_t cond
);

    logic signed [23:0] s24;
    logic [3:0]         gain;
    logic [3:0]         shift;
    logic signed [23:0] amp;
    logic               neg;
    logic [23:0]        mag;
    logic               above;
    logic [23:0]        diff;
    logic [21:0]        over;
    logic               capped;
    logic [14:0]        over_lim;
    logic [15:0]        knee_mag;
    logic [15:0]        knee_val;

    // Extract the 24-bit sample and apply gain as a floor shift
    assign s24   = signed'(slot_word[31:8]);
    assign gain  = (cfg.gain_shift > msks_pkg::GAIN_SHIFT_MAX) ?
                   msks_pkg::GAIN_SHIFT_MAX : cfg.gain_shift;
    assign shift = msks_pkg::GAIN_SHIFT_MAX - gain;
    assign amp   = s24 >>> shift;

    // Magnitude; the most negative value maps to 2^23 as unsigned
    assign neg = amp[23];
    assign mag = neg ? (~unsigned'(amp) + 24'd1) : unsigned'(amp);

    // Compress overshoot 4:1 and cap it at the headroom
    assign above    = mag > {9'd0, cfg.knee_threshold};
    assign diff     = mag - {9'd0, cfg.knee_threshold};
    assign over     = diff[23:2];
    assign capped   = over > {7'd0, cfg.knee_headroom};
    assign over_lim = capped ? cfg.knee_headroom : over[14:0];
    assign knee_mag = {1'b0, cfg.knee_threshold} + {1'b0, over_lim};
    assign knee_val = neg ? (~knee_mag + 16'd1) : knee_mag;

    // Truncate to 16 bits
    assign cond.pcm  = above ? knee_val : amp[15:0];
    assign cond.clip = above && capped;

endmodule

// ===== sv/msks_stats.sv =====
// Running level statistics, frame position and the result register.
module msks_stats (
    input  logic              clk,
    input  logic              rst_n,
    input  msks_pkg::cfg_t    cfg,
    input  logic              stage_valid,
    input  logic              clear_stats,
    input  msks_pkg::cond_t   cond,
    output logic              take,
    output logic              result_valid,
    input  logic              result_stall,
    output msks_pkg::result_t result
);

    logic signed [15:0]              min_reg,  min_next,  min_base;
    logic signed [15:0]              max_reg,  max_next,  max_base;
    logic [15:0]                     or_reg,   or_next,   or_base;
    logic [15:0]                     and_reg,  and_next,  and_base;
    logic [31:0]                     count_reg, count_next, count_base;
    logic [msks_pkg::SUM_WIDTH-1:0]  sum_reg,  sum_next,  sum_base;
    logic [31:0]                     clips_reg, clips_next, clips_base;
    logic [9:0]                      pos_reg,  pos_next,  pos_base;
    logic                            valid_reg, valid_next;
    msks_pkg::result_t               result_reg, result_next;

    logic signed [15:0] s;
    logic [16:0]        sx;
    logic [16:0]        abs_val;
    logic [10:0]        pos1;
    logic               fend;
    logic [63:0]        sum_wide;

    // Move the held item into the result register when it is free or draining
    assign take = stage_valid && (!valid_reg || !result_stall);

    always_comb
    begin
        // Restart statistics ahead of this sample on clear
        if (clear_stats)
        begin
            min_base   = msks_pkg::LEVEL_MIN_INIT;
            max_base   = msks_pkg::LEVEL_MAX_INIT;
            or_base    = msks_pkg::BITS_OR_INIT;
            and_base   = msks_pkg::BITS_AND_INIT;
            count_base = '0;
            sum_base   = '0;
            clips_base = '0;
            pos_base   = '0;
        end
        else
        begin
            min_base   = min_reg;
            max_base   = max_reg;
            or_base    = or_reg;
            and_base   = and_reg;
            count_base = count_reg;
            sum_base   = sum_reg;
            clips_base = clips_reg;
            pos_base   = pos_reg;
        end

        s       = signed'(cond.pcm);
        sx      = {cond.pcm[15], cond.pcm};
        abs_val = cond.pcm[15] ? (~sx + 17'd1) : sx;

        min_next   = (s < min_base) ? s : min_base;
        max_next   = (s > max_base) ? s : max_base;
        or_next    = or_base | cond.pcm;
        and_next   = and_base & cond.pcm;
        count_next = count_base + 32'd1;
        sum_next   = sum_base + msks_pkg::SUM_WIDTH'(abs_val);
        clips_next = clips_base + {31'd0, cond.clip};

        // Advance frame position, wrap at the frame length (1 to 1024; other lengths never end a frame)
        pos1     = {1'b0, pos_base} + 11'd1;
        fend     = (pos1 == cfg.frame_length);
        pos_next = fend ? 10'd0 : pos1[9:0];

        sum_wide = 64'(sum_next);

        result_next.pcm_sample   = s;
        result_next.clipped      = cond.clip;
        result_next.frame_end    = fend;
        result_next.level_min    = min_next;
        result_next.level_max    = max_next;
        result_next.bits_or      = or_next;
        result_next.bits_and     = and_next;
        result_next.sample_count = count_next;
        result_next.abs_sum      = sum_wide[msks_pkg::ABS_SUM_WIDTH-1:0];
        result_next.clip_count   = clips_next;

        // Hold a stalled result, drop a delivered one
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= msks_pkg::LEVEL_MIN_INIT;
            max_reg   <= msks_pkg::LEVEL_MAX_INIT;
            or_reg    <= msks_pkg::BITS_OR_INIT;
            and_reg   <= msks_pkg::BITS_AND_INIT;
            count_reg <= '0;
            sum_reg   <= '0;
            clips_reg <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                min_reg   <= min_next;
                max_reg   <= max_next;
                or_reg    <= or_next;
                and_reg   <= and_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
                clips_reg <= clips_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    // A frame end always restarts the frame position
    a_frame_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take && fend |=> pos_reg == 10'd0)
        else $error("frame position not restarted after frame end");

    // Every result has seen at least one sample, so min cannot exceed max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> result_reg.level_min <= result_reg.level_max)
        else $error("level_min above level_max");

    // AND of patterns is a subset of their OR
    a_and_within_or: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (result_reg.bits_and & ~result_reg.bits_or) == 16'd0)
        else $error("bits_and has a bit outside bits_or");

    // A sample taken while the result is stalled must not overwrite it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_stall |-> !take)
        else $error("stalled result overwritten");

endmodule

// ===== sv/mic_sample_soft_knee_stats_core.sv =====
// Top level of the microphone soft-knee limiter with level statistics.
//
//   channel   direction  handshake                payload
//   sample    in         sample_valid/stall       msks_pkg::sample_t
//   result    out        result_valid/stall       msks_pkg::result_t
//   config    in         APB psel/penable/pready  32-bit registers at 4*index
//
// One sample per cycle sustained while the result is not stalled; a sample passes
// through the input register and then the result register in series.
// The statistics feedback lets a new sample update every cycle unless the result stalls.
// A stalled result holds while one further sample waits in the input register.
// Reset clears valids, statistics and restores the register defaults.
module mic_sample_soft_knee_stats_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  msks_pkg::sample_t                  sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output msks_pkg::result_t                  result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msks_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [msks_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [msks_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                               pready
);

    msks_pkg::cfg_t    cfg;
    msks_pkg::sample_t stage_data;
    msks_pkg::cond_t   cond;
    logic              stage_valid;
    logic              take;

    msks_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msks_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .take         (take),
        .stage_valid  (stage_valid),
        .stage_data   (stage_data)
    );

    msks_limiter u_limiter (
        .slot_word (stage_data.slot_word),
        .cfg       (cfg),
        .cond      (cond)
    );

    msks_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .stage_valid  (stage_valid),
        .clear_stats  (stage_data.clear_stats),
        .cond         (cond),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
